>>> sv/cumms_pkg.sv
// Package: shared types, constants and calendar helpers for the epoch converter.
`default_nettype none
package cumms_pkg;

  // Field widths
  localparam int FIELD_W  = 7;
  localparam int ACC_W    = 43;
  localparam int MILLIS_W = 42;
  localparam int MULT_W   = 10;
  localparam int ADD_W    = 17;

  // Year offsets counted from 1970
  localparam logic [7:0] CENTURY_OFFSET = 8'd30;   // 2000 - 1970
  localparam logic [7:0] Y2100_OFFSET   = 8'd130;  // 2100 - 1970
  localparam logic [6:0] Y2100_IN_CENT  = 7'd100;  // 2100 - 2000

  // Scale factors
  localparam logic [MULT_W-1:0] MUL_ONE    = 10'd1;
  localparam logic [MULT_W-1:0] MUL_HOURS  = 10'd24;
  localparam logic [MULT_W-1:0] MUL_SIXTY  = 10'd60;
  localparam logic [MULT_W-1:0] MUL_MILLIS = 10'd1000;

  localparam logic [ADD_W-1:0] DAYS_COMMON = 17'd365;
  localparam logic [ADD_W-1:0] DAYS_LEAP   = 17'd366;

  // Control for the shared multiply-accumulate unit
  typedef struct packed {
    logic                clear;
    logic                en;
    logic [MULT_W-1:0]   mult;
    logic [ADD_W-1:0]    addend;
  } mac_ctl_t;

  // Leap test for a year given as offset from 1970 (covers 1970..2199)
  function automatic logic leap_from_1970(input logic [7:0] k);
    leap_from_1970 = (k[1:0] == 2'd2) && (k != Y2100_OFFSET);
  endfunction

  // Leap test for a year given within the 2000 century (covers 2000..2127)
  function automatic logic leap_in_century(input logic [FIELD_W-1:0] y);
    leap_in_century = (y[1:0] == 2'd0) && (y != Y2100_IN_CENT);
  endfunction

  // Month length, with February stretched in leap years
  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    case (m)
      4'd2:    month_days = leap ? 5'd29 : 5'd28;
      4'd4:    month_days = 5'd30;
      4'd6:    month_days = 5'd30;
      4'd9:    month_days = 5'd30;
      4'd11:   month_days = 5'd30;
      default: month_days = 5'd31;
    endcase
  endfunction

endpackage
`default_nettype wire

>>> sv/cumms_if.sv
// Interfaces: clock reading request channel and epoch result channel.
`default_nettype none
interface cumms_stamp_if;
  logic                          valid;
  logic                          ready;
  logic [cumms_pkg::FIELD_W-1:0] year_in_century;
  logic [cumms_pkg::FIELD_W-1:0] month_number;
  logic [cumms_pkg::FIELD_W-1:0] day_of_month;
  logic [cumms_pkg::FIELD_W-1:0] hour_of_day;
  logic [cumms_pkg::FIELD_W-1:0] minute_of_hour;
  logic [cumms_pkg::FIELD_W-1:0] second_of_minute;

  modport source (
    output valid, year_in_century, month_number, day_of_month,
           hour_of_day, minute_of_hour, second_of_minute,
    input  ready
  );
  modport sink (
    input  valid, year_in_century, month_number, day_of_month,
           hour_of_day, minute_of_hour, second_of_minute,
    output ready
  );
endinterface

interface cumms_result_if;
  logic                           valid;
  logic                           ready;
  logic [cumms_pkg::MILLIS_W-1:0] epoch_millis;
  logic                           time_valid;

  modport source (output valid, epoch_millis, time_valid, input ready);
  modport sink   (input valid, epoch_millis, time_valid, output ready);
endinterface
`default_nettype wire

>>> sv/cumms_mac.sv
// Shared multiply-accumulate unit: acc <= acc * mult + addend.
`default_nettype none
module cumms_mac (
  input  wire logic                        clk,
  input  wire cumms_pkg::mac_ctl_t         ctl,
  output logic [cumms_pkg::ACC_W-1:0]      acc
);

  logic [cumms_pkg::ACC_W+cumms_pkg::MULT_W-1:0] wide;

  // Scale and add in one step; real values stay within the accumulator
  assign wide = acc * ctl.mult
              + {{(cumms_pkg::ACC_W+cumms_pkg::MULT_W-cumms_pkg::ADD_W){1'b0}}, ctl.addend};

  // Hold, clear or advance the accumulator
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (ctl.en) begin
      acc <= wide[cumms_pkg::ACC_W-1:0];
    end
  end

endmodule
`default_nettype wire

>>> sv/calendar_to_unix_milliseconds.sv
// Top level: clock reading to Unix epoch milliseconds, sequenced over one shared MAC.
//
// Channel stamp carries one clock reading (two-digit year of the 2000
// century, month, day, hour, minute, second); channel result returns one
// item per request: epoch_millis and time_valid. Both use valid/ready.
// A request is taken only while the sequencer is idle. The sequencer
// walks the years one per cycle, then the months one per cycle, then
// five scale steps (day, x24 + hour, x60 + minute, x60 + second, x1000),
// all through one multiply-accumulate unit; a new request is not taken
// until the sequencer has handed over the last one. A rejected reading
// (month outside 1..12 or day zero) goes straight to the done state
// with zero and time_valid low. Results above 42 bits saturate to all ones.
// The result sits in an output register; a new request is taken while it
// waits, and the next result holds in the sequencer until the receiver
// takes the previous one. Synchronous reset returns to idle with no
// result pending.
`default_nettype none
module calendar_to_unix_milliseconds (
  input  wire logic       clk,
  input  wire logic       rst,
  cumms_stamp_if.sink     stamp,
  cumms_result_if.source  result
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_YEAR  = 3'd1;
  localparam logic [2:0] S_MONTH = 3'd2;
  localparam logic [2:0] S_SCALE = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam logic [2:0] STEP_DAY    = 3'd0;
  localparam logic [2:0] STEP_HOUR   = 3'd1;
  localparam logic [2:0] STEP_MINUTE = 3'd2;
  localparam logic [2:0] STEP_SECOND = 3'd3;
  localparam logic [2:0] STEP_MILLIS = 3'd4;

  logic [2:0]                      state;
  logic [2:0]                      step;
  logic [7:0]                      year_cnt;
  logic [7:0]                      year_end;
  logic [3:0]                      month_cnt;
  logic                            ok;
  logic [cumms_pkg::FIELD_W-1:0]   yic;
  logic [cumms_pkg::FIELD_W-1:0]   mon;
  logic [cumms_pkg::FIELD_W-1:0]   day;
  logic [cumms_pkg::FIELD_W-1:0]   hr;
  logic [cumms_pkg::FIELD_W-1:0]   mi;
  logic [cumms_pkg::FIELD_W-1:0]   se;
  logic                            out_valid;
  logic [cumms_pkg::MILLIS_W-1:0]  out_millis;
  logic                            out_ok;

  cumms_pkg::mac_ctl_t             ctl;
  logic [cumms_pkg::ACC_W-1:0]     acc;
  logic                            take;
  logic                            bad;
  logic                            out_free;

  cumms_mac u_mac (
    .clk (clk),
    .ctl (ctl),
    .acc (acc)
  );

  assign stamp.ready = (state == S_IDLE);
  assign take        = stamp.valid && stamp.ready;
  assign bad         = (stamp.month_number == 7'd0) || (stamp.month_number > 7'd12)
                    || (stamp.day_of_month == 7'd0);
  assign out_free    = !out_valid || result.ready;

  // Drive the shared unit from the current sequencer step
  always_comb begin
    ctl.clear  = 1'b0;
    ctl.en     = 1'b0;
    ctl.mult   = cumms_pkg::MUL_ONE;
    ctl.addend = '0;
    case (state)
      S_IDLE: begin
        ctl.clear = take;
      end
      S_YEAR: begin
        ctl.en     = 1'b1;
        ctl.addend = cumms_pkg::leap_from_1970(year_cnt) ? cumms_pkg::DAYS_LEAP
                                                         : cumms_pkg::DAYS_COMMON;
      end
      S_MONTH: begin
        ctl.en     = (month_cnt != mon[3:0]);
        ctl.addend = {12'd0, cumms_pkg::month_days(month_cnt,
                                                   cumms_pkg::leap_in_century(yic))};
      end
      S_SCALE: begin
        ctl.en = 1'b1;
        case (step)
          STEP_DAY: begin
            ctl.addend = {10'd0, day - 7'd1};
          end
          STEP_HOUR: begin
            ctl.mult   = cumms_pkg::MUL_HOURS;
            ctl.addend = {10'd0, hr};
          end
          STEP_MINUTE: begin
            ctl.mult   = cumms_pkg::MUL_SIXTY;
            ctl.addend = {10'd0, mi};
          end
          STEP_SECOND: begin
            ctl.mult   = cumms_pkg::MUL_SIXTY;
            ctl.addend = {10'd0, se};
          end
          default: begin
            ctl.mult   = cumms_pkg::MUL_MILLIS;
          end
        endcase
      end
      default: begin
        ctl.en = 1'b0;
      end
    endcase
  end

  // Capture the request fields
  always_ff @(posedge clk) begin
    if (take) begin
      yic      <= stamp.year_in_century;
      mon      <= stamp.month_number;
      day      <= stamp.day_of_month;
      hr       <= stamp.hour_of_day;
      mi       <= stamp.minute_of_hour;
      se       <= stamp.second_of_minute;
      year_end <= {1'b0, stamp.year_in_century} + cumms_pkg::CENTURY_OFFSET;
    end
  end

  // Sequencer: years, months, scale steps (skipped for a rejected reading), then hand over the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= STEP_DAY;
      year_cnt  <= '0;
      month_cnt <= 4'd1;
      ok        <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (take) begin
            year_cnt  <= '0;
            month_cnt <= 4'd1;
            step      <= STEP_DAY;
            ok        <= !bad;
            state     <= bad ? S_DONE : S_YEAR;
          end
        end
        S_YEAR: begin
          year_cnt <= year_cnt + 8'd1;
          if (year_cnt + 8'd1 == year_end) begin
            state <= S_MONTH;
          end
        end
        S_MONTH: begin
          if (month_cnt == mon[3:0]) begin
            state <= S_SCALE;
          end else begin
            month_cnt <= month_cnt + 4'd1;
          end
        end
        S_SCALE: begin
          step <= step + 3'd1;
          if (step == STEP_MILLIS) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: load when free, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_ok <= ok;
      if (!ok) begin
        out_millis <= '0;
      end else if (acc[cumms_pkg::ACC_W-1]) begin
        out_millis <= '1;
      end else begin
        out_millis <= acc[cumms_pkg::MILLIS_W-1:0];
      end
    end
  end

  assign result.valid        = out_valid;
  assign result.epoch_millis = out_millis;
  assign result.time_valid   = out_ok;

endmodule
`default_nettype wire
